// ----- rtl/sibd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sibd_pkg
// Shared types and constants for the split index bit deposit core: word
// layouts of both channels, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package sibd_pkg;

    localparam int INDEX_WIDTH_DEF = 32;

    localparam int SRC_W     = 16;
    localparam int SRC_SEL_W = 4;
    localparam int OUT_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int IMAG_BIT_W  = 5;
    localparam int LANE_CNT_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_PARTITION_MASK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LANE_MASK      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAG_BIT       = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LANE_COUNT     = 2'd3;

    typedef struct packed {
        logic [SRC_W-1:0] partition_index;
        logic [SRC_W-1:0] lane_index;
    } in_word_t;

    typedef struct packed {
        logic [OUT_W-1:0] real_index;
        logic [OUT_W-1:0] imag_index;
        logic [OUT_W-1:0] table_slot;
    } out_word_t;

endpackage
`default_nettype wire

// ----- rtl/split_index_bit_deposit_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// split_index_bit_deposit_core
// Interleaved-load index generator: bit deposit of partition and lane indexes
// into configured masks, imaginary index and table slot.
// ----------------------------------------------------------------------------
// The core takes one word per cycle and returns each result through a
// four-stage pipeline (input register, slot multiplier, bit deposit
// network, imaginary bit and output register) in which every stage holds
// its word while the stage after it cannot load. Throughput is one word
// per clock whenever m_ready is high. The deposit network works
// from per-position bit ranks that are registered from the mask registers, so
// a mask write applies to words accepted in the same cycle as the write or
// later. Only the low INDEX_WIDTH bits of the masks are used, and both index
// outputs are zero above INDEX_WIDTH.
module split_index_bit_deposit_core #(
    parameter int INDEX_WIDTH = sibd_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             cfg_we,
    input  wire logic [sibd_pkg::CFG_INDEX_W-1:0] cfg_addr,
    input  wire logic [sibd_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire sibd_pkg::in_word_t               s_data,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output sibd_pkg::out_word_t                   m_data
);

    logic [INDEX_WIDTH-1:0]              part_mask_reg;
    logic [INDEX_WIDTH-1:0]              lane_mask_reg;
    logic [sibd_pkg::IMAG_BIT_W-1:0]     imag_bit_reg;
    logic [sibd_pkg::LANE_CNT_W-1:0]     lane_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_mask_reg  <= '0;
            lane_mask_reg  <= '0;
            imag_bit_reg   <= '0;
            lane_count_reg <= sibd_pkg::LANE_CNT_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                sibd_pkg::REG_PARTITION_MASK: part_mask_reg <= cfg_wdata[INDEX_WIDTH-1:0];
                sibd_pkg::REG_LANE_MASK:      lane_mask_reg <= cfg_wdata[INDEX_WIDTH-1:0];
                sibd_pkg::REG_IMAG_BIT:
                    imag_bit_reg <= cfg_wdata[sibd_pkg::IMAG_BIT_W-1:0];
                sibd_pkg::REG_LANE_COUNT:
                    lane_count_reg <= cfg_wdata[sibd_pkg::LANE_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline valid bits and load enables; a stage loads when it is empty
    // or when the stage after it loads.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    assign ld4     = !v4_reg || m_ready;
    assign ld3     = !v3_reg || ld4;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign s_ready = ld1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: input register.
    sibd_pkg::in_word_t s1_word_reg;

    always_ff @(posedge aclk) begin
        if (ld1 && s_valid) begin
            s1_word_reg <= s_data;
        end
    end

    // Stage 2: partition times lane count, wrapped to the slot width.
    logic [sibd_pkg::SRC_W-1:0] s2_part_reg;
    logic [sibd_pkg::SRC_W-1:0] s2_lane_reg;
    logic [sibd_pkg::OUT_W-1:0] s2_prod_reg;
    logic [sibd_pkg::SRC_W+sibd_pkg::LANE_CNT_W-1:0] prod_full;

    assign prod_full = (sibd_pkg::SRC_W+sibd_pkg::LANE_CNT_W)'(s1_word_reg.partition_index)
                     * (sibd_pkg::SRC_W+sibd_pkg::LANE_CNT_W)'(lane_count_reg);

    always_ff @(posedge aclk) begin
        if (ld2 && v1_reg) begin
            s2_part_reg <= s1_word_reg.partition_index;
            s2_lane_reg <= s1_word_reg.lane_index;
            s2_prod_reg <= prod_full[sibd_pkg::OUT_W-1:0];
        end
    end

    // Stage 3: bit deposit of both indexes and slot addition.
    logic [INDEX_WIDTH-1:0]     part_dep;
    logic [INDEX_WIDTH-1:0]     lane_dep;
    logic [INDEX_WIDTH-1:0]     s3_real_reg;
    logic [sibd_pkg::OUT_W-1:0] s3_slot_reg;

    sibd_deposit #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_part_dep (
        .aclk   (aclk),
        .mask   (part_mask_reg),
        .src    (s2_part_reg),
        .result (part_dep)
    );

    sibd_deposit #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_lane_dep (
        .aclk   (aclk),
        .mask   (lane_mask_reg),
        .src    (s2_lane_reg),
        .result (lane_dep)
    );

    always_ff @(posedge aclk) begin
        if (ld3 && v2_reg) begin
            s3_real_reg <= part_dep | lane_dep;
            s3_slot_reg <= s2_prod_reg + sibd_pkg::OUT_W'(s2_lane_reg);
        end
    end

    // Stage 4: imaginary select bit and output register.
    logic [sibd_pkg::OUT_W-1:0] imag_onehot;
    logic [INDEX_WIDTH-1:0]     imag_idx;
    sibd_pkg::out_word_t        out_word_reg;

    assign imag_onehot = sibd_pkg::OUT_W'(1) << imag_bit_reg;
    assign imag_idx    = s3_real_reg | imag_onehot[INDEX_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (ld4 && v3_reg) begin
            out_word_reg.real_index <= sibd_pkg::OUT_W'(s3_real_reg);
            out_word_reg.imag_index <= sibd_pkg::OUT_W'(imag_idx);
            out_word_reg.table_slot <= s3_slot_reg;
        end
    end

    assign m_data = out_word_reg;

endmodule
`default_nettype wire

// ----- rtl/sibd_deposit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sibd_deposit
// Parallel bit deposit of a 16-bit source into the set positions of a mask.
// The rank of every mask position is registered once per cycle from the mask.
// ----------------------------------------------------------------------------
module sibd_deposit #(
    parameter int INDEX_WIDTH = sibd_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic [INDEX_WIDTH-1:0]     mask,
    input  wire logic [sibd_pkg::SRC_W-1:0] src,
    output logic      [INDEX_WIDTH-1:0]     result
);

    localparam int RANK_W = (INDEX_WIDTH > 1) ? $clog2(INDEX_WIDTH) : 1;

    logic [RANK_W-1:0] rank_reg  [INDEX_WIDTH];
    logic [RANK_W-1:0] rank_next [INDEX_WIDTH];

    // The rank of a position is the number of mask bits set below it, which is
    // the source bit that lands there.
    always_comb begin
        for (int pos = 0; pos < INDEX_WIDTH; pos++) begin
            rank_next[pos] = RANK_W'($countones(
                mask & INDEX_WIDTH'((64'd1 << pos) - 64'd1)));
        end
    end

    always_ff @(posedge aclk) begin
        for (int pos = 0; pos < INDEX_WIDTH; pos++) begin
            rank_reg[pos] <= rank_next[pos];
        end
    end

    always_comb begin
        logic [31:0] rank_ext;
        rank_ext = '0;
        for (int pos = 0; pos < INDEX_WIDTH; pos++) begin
            rank_ext    = 32'(rank_reg[pos]);
            result[pos] = mask[pos] && (rank_ext < 32'(sibd_pkg::SRC_W)) &&
                          src[rank_ext[sibd_pkg::SRC_SEL_W-1:0]];
        end
    end

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for split_index_bit_deposit_core. Directed words cover
// the mask, imaginary bit and lane count corners. Random words then run
// under a series of random register settings, with random gaps on both
// channels outside one flat-out phase. Each result word is checked field by field
// against a behavioral model of the bit deposit and table slot arithmetic.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IW              = sibd_pkg::INDEX_WIDTH_DEF;
    localparam int WORDS_PER_PHASE = 200;
    localparam int RANDOM_PHASES   = 10;
    localparam int DEFAULT_IDLE    = 22;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [sibd_pkg::CFG_INDEX_W-1:0] cfg_addr  = '0;
    logic [sibd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    sibd_pkg::in_word_t               s_data    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    sibd_pkg::out_word_t              m_data;

    // Copy of the register file as the core should hold it.
    logic [sibd_pkg::OUT_W-1:0]      part_mask_cfg  = '0;
    logic [sibd_pkg::OUT_W-1:0]      lane_mask_cfg  = '0;
    logic [sibd_pkg::IMAG_BIT_W-1:0] imag_bit_cfg   = '0;
    logic [sibd_pkg::LANE_CNT_W-1:0] lane_count_cfg = sibd_pkg::LANE_CNT_W'(1);

    sibd_pkg::out_word_t index_queue[$];
    sibd_pkg::out_word_t expected_word;
    int                  error_count   = 0;
    int                  send_idle_pct = DEFAULT_IDLE;
    int                  recv_idle_pct = DEFAULT_IDLE;

    split_index_bit_deposit_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [sibd_pkg::OUT_W-1:0] deposit_bits(
        input logic [sibd_pkg::SRC_W-1:0] src,
        input logic [sibd_pkg::OUT_W-1:0] mask);
        logic [sibd_pkg::OUT_W-1:0] dep;
        int                         take;
        dep  = '0;
        take = 0;
        for (int pos = 0; pos < sibd_pkg::OUT_W; pos++) begin
            if (mask[pos]) begin
                if (take < sibd_pkg::SRC_W && src[take]) dep[pos] = 1'b1;
                take++;
            end
        end
        return dep;
    endfunction

    function automatic sibd_pkg::out_word_t predict_indexes(input sibd_pkg::in_word_t w);
        logic [sibd_pkg::OUT_W-1:0] width_mask;
        logic [sibd_pkg::OUT_W-1:0] re;
        logic [sibd_pkg::OUT_W-1:0] im;
        logic [sibd_pkg::OUT_W-1:0] slot;
        width_mask = sibd_pkg::OUT_W'((64'd1 << IW) - 64'd1);
        re = (deposit_bits(w.partition_index, part_mask_cfg & width_mask)
            | deposit_bits(w.lane_index, lane_mask_cfg & width_mask)) & width_mask;
        im = (re | (sibd_pkg::OUT_W'(1) << imag_bit_cfg)) & width_mask;
        // The slot wraps modulo 2^32 through the width of the assignment.
        slot = w.partition_index * lane_count_cfg + w.lane_index;
        return '{real_index: re, imag_index: im, table_slot: slot};
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [sibd_pkg::OUT_W-1:0] want,
                               input logic [sibd_pkg::OUT_W-1:0] got);
        if (got !== want) note_error($sformatf("%s: expected %h, got %h", name, want, got));
    endtask

    task automatic add_expected(input sibd_pkg::out_word_t w);
        index_queue.insert(index_queue.size(), w);
    endtask

    // Results are checked before the word accepted at the same edge is predicted;
    // the pipeline latency keeps the two apart.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (index_queue.size() == 0) begin
                    note_error($sformatf("result word %h with nothing expected", m_data));
                end else begin
                    expected_word = index_queue.pop_front();
                    check_field("real_index", expected_word.real_index, m_data.real_index);
                    check_field("imag_index", expected_word.imag_index, m_data.imag_index);
                    check_field("table_slot", expected_word.table_slot, m_data.table_slot);
                end
            end
            if (s_valid && s_ready) add_expected(predict_indexes(s_data));
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic [sibd_pkg::SRC_W-1:0] part,
                             input logic [sibd_pkg::SRC_W-1:0] lane);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= '{partition_index: part, lane_index: lane};
        do @(posedge aclk); while (!s_ready);
    endtask

    // The first edge lets the checker record the last word accepted.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (index_queue.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sibd_pkg::CFG_INDEX_W-1:0] addr,
                             input logic [sibd_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            sibd_pkg::REG_PARTITION_MASK: part_mask_cfg  = data;
            sibd_pkg::REG_LANE_MASK:      lane_mask_cfg  = data;
            sibd_pkg::REG_IMAG_BIT:       imag_bit_cfg   = data[sibd_pkg::IMAG_BIT_W-1:0];
            sibd_pkg::REG_LANE_COUNT:     lane_count_cfg = data[sibd_pkg::LANE_CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Unused upper bits of the narrow registers carry random junk.
    task automatic set_config(input logic [sibd_pkg::OUT_W-1:0] pm,
                              input logic [sibd_pkg::OUT_W-1:0] lm,
                              input logic [sibd_pkg::IMAG_BIT_W-1:0] ib,
                              input logic [sibd_pkg::LANE_CNT_W-1:0] lc);
        logic [sibd_pkg::CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = $urandom;
        write_reg(sibd_pkg::REG_PARTITION_MASK, pm);
        write_reg(sibd_pkg::REG_LANE_MASK, lm);
        write_reg(sibd_pkg::REG_IMAG_BIT,
                  {junk[sibd_pkg::CFG_DATA_W-1:sibd_pkg::IMAG_BIT_W], ib});
        write_reg(sibd_pkg::REG_LANE_COUNT,
                  {junk[sibd_pkg::CFG_DATA_W-1:sibd_pkg::LANE_CNT_W], lc});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [sibd_pkg::SRC_W-1:0] rand_index();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return sibd_pkg::SRC_W'($urandom);
        endcase
    endfunction

    function automatic logic [sibd_pkg::OUT_W-1:0] rand_mask();
        int n;
        int s;
        n = $urandom_range(32, 1);
        s = $urandom_range(32 - n);
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom & $urandom & $urandom;
            3:       return sibd_pkg::OUT_W'(((64'd1 << n) - 64'd1) << s);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [sibd_pkg::LANE_CNT_W-1:0] rand_lane_count();
        case ($urandom_range(3))
            0:       return sibd_pkg::LANE_CNT_W'($urandom_range(3));
            1:       return sibd_pkg::LANE_CNT_W'($urandom_range(131071, 65536));
            default: return sibd_pkg::LANE_CNT_W'($urandom_range(131071));
        endcase
    endfunction

    task automatic test_reset_values();
        send_word(16'h0000, 16'h0000);
        send_word(16'hFFFF, 16'hFFFF);
    endtask

    // All partition bits land low; the largest lane count makes the slot wrap.
    task automatic test_full_partition_mask();
        set_config(32'hFFFF_FFFF, 32'h0000_0000, 5'd31, 17'h1FFFF);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'h0000, 16'hFFFF);
        send_word(16'hFFFF, 16'h0000);
        send_word(16'hAAAA, 16'h5555);
    endtask

    // Disjoint masks, and a zero lane count that leaves the slot equal to the lane.
    task automatic test_split_masks();
        set_config(32'h0000_FFFF, 32'hFFFF_0000, 5'd30, 17'd0);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'h1234, 16'hABCD);
        send_word(16'h0000, 16'h0001);
    endtask

    task automatic test_overlapping_masks();
        set_config(32'hAAAA_AAAA, 32'hAAAA_AAAA, 5'd5, 17'd65536);
        send_word(16'hFFFF, 16'h0000);
        send_word(16'h5555, 16'hAAAA);
        send_word(16'h8001, 16'h8001);
    endtask

    // Masks with fewer set bits than the source drop the upper source bits.
    task automatic test_short_masks();
        set_config(32'h0000_0007, 32'h8000_0001, 5'd0, 17'd1);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'h0008, 16'h0003);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // One phase runs with both channels flat out.
            if (ph == RANDOM_PHASES / 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = DEFAULT_IDLE;
                recv_idle_pct = DEFAULT_IDLE;
            end
            set_config(rand_mask(), rand_mask(),
                       sibd_pkg::IMAG_BIT_W'($urandom_range(31)), rand_lane_count());
            repeat (WORDS_PER_PHASE) send_word(rand_index(), rand_index());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_full_partition_mask();
        test_split_masks();
        test_overlapping_masks();
        test_short_masks();
        test_random_phases();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sibd_pkg.sv
rtl/sibd_deposit.sv
rtl/split_index_bit_deposit_core.sv
bench/tb_top.sv
